FILE: hdl/tihm_pkg.sv
// tihm_pkg: shared types, codes and hash helpers for the tunnel IP hash map.
// No dependencies; used by the slot RAM, modulo unit, map unit and bench.
package tihm_pkg;

    // request kinds
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam int SLOT_INDEX_W = 10;

    // 64-bit FNV offset basis; prime 0x100000001b3 = 2^40 + 0x1b3
    localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;

    // bits of the 64-bit hash reduced per cycle in the modulo unit
    localparam int MOD_BITS_PER_CYCLE = 4;
    localparam int MOD_CYCLES         = 64 / MOD_BITS_PER_CYCLE;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_PROBE
    } tihm_state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] tunnel_key;
        logic [31:0] inner_addr;
        logic [31:0] outer_addr;
    } slot_entry_t;

    // h * prime mod 2^64 as a shift plus a 64x9 constant product
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        logic [63:0] lo;
        lo = h * {55'b0, FNV_PRIME_LO};
        return (h << FNV_PRIME_SHIFT) + lo;
    endfunction

endpackage

FILE: hdl/tihm_req_if.sv
// tihm_req_if: request channel (valid/ready plus request word).
// Depends on nothing.
interface tihm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] tunnel_key;
    logic [31:0] inner_addr;
    logic [31:0] new_outer_addr;

    modport source (
        output valid, req_type, tunnel_key, inner_addr, new_outer_addr,
        input  ready
    );
    modport sink (
        input  valid, req_type, tunnel_key, inner_addr, new_outer_addr,
        output ready
    );
endinterface

FILE: hdl/tihm_rsp_if.sv
// tihm_rsp_if: response channel (valid/ready plus result word).
// Depends on nothing.
interface tihm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] found_outer_addr;
    logic [9:0]  slot_index;

    modport source (
        output valid, status, found_outer_addr, slot_index,
        input  ready
    );
    modport sink (
        input  valid, status, found_outer_addr, slot_index,
        output ready
    );
endinterface

FILE: hdl/tihm_slot_ram.sv
// tihm_slot_ram: slot store, one write and one read port, registered read data.
// Depends on tihm_pkg (slot_entry_t).
module tihm_slot_ram #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  tihm_pkg::slot_entry_t          wr_data,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output tihm_pkg::slot_entry_t          rd_data
);

    tihm_pkg::slot_entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/tihm_mod_unit.sv
// tihm_mod_unit: reduces the 64-bit hash to a slot number (hash mod depth).
// Power-of-two depth: registered mask of the low bits. Otherwise bit-serial, 4 bits a cycle.
// Depends on tihm_pkg.
module tihm_mod_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [63:0]                    value,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] result
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2  = (TABLE_DEPTH == (1 << IDX_W));
    localparam int CNT_W    = $clog2(tihm_pkg::MOD_CYCLES);

    logic done_reg;
    logic done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign done = done_reg;

    if (IS_POW2)
    begin : g_mask
        logic [IDX_W-1:0] res_reg;

        assign done_next = start;

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                res_reg <= value[IDX_W-1:0];
            end
        end

        assign result = res_reg;
    end
    else
    begin : g_serial
        logic [63:0]      val_reg;
        logic [63:0]      val_next;
        logic [IDX_W-1:0] rem_reg;
        logic [IDX_W-1:0] rem_next;
        logic [CNT_W-1:0] cnt_reg;
        logic [CNT_W-1:0] cnt_next;
        logic             busy_reg;
        logic             busy_next;
        logic [IDX_W-1:0] rem_step;

        // restoring reduction: r = (2r + bit) mod depth, MSB first
        always_comb
        begin
            logic [IDX_W:0]   t;
            logic [IDX_W-1:0] r;
            r = rem_reg;
            for (int j = 0; j < tihm_pkg::MOD_BITS_PER_CYCLE; j++)
            begin
                t = {r, val_reg[63-j]};
                if (t >= (IDX_W+1)'(TABLE_DEPTH))
                begin
                    t = t - (IDX_W+1)'(TABLE_DEPTH);
                end
                r = t[IDX_W-1:0];
            end
            rem_step = r;
        end

        always_comb
        begin
            val_next  = val_reg;
            rem_next  = rem_reg;
            cnt_next  = cnt_reg;
            busy_next = busy_reg;
            done_next = 1'b0;
            if (start)
            begin
                val_next  = value;
                rem_next  = '0;
                cnt_next  = '0;
                busy_next = 1'b1;
            end
            else if (busy_reg)
            begin
                val_next = val_reg << tihm_pkg::MOD_BITS_PER_CYCLE;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(tihm_pkg::MOD_CYCLES - 1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg <= val_next;
            rem_reg <= rem_next;
        end

        assign result = rem_reg;
    end

endmodule

FILE: hdl/tunnel_ip_hash_map_unit.sv
// tunnel_ip_hash_map_unit: open-addressed map (tunnel key, inner IPv4) -> outer IPv4.
// Depends on tihm_pkg, tihm_req_if, tihm_rsp_if, tihm_mod_unit, tihm_slot_ram.
//
// After reset the block runs a clearing pass over every slot of the slot
// memory (req.ready low meanwhile). It then serves one request word at a
// time: accept and first hash multiply, second multiply into the modulo
// unit, slot reduction (a registered mask for a power-of-two depth, the
// bit-serial reduction otherwise), then one probe per cycle through the
// single read port of the slot memory. A full-table walk costs TABLE_DEPTH
// probes. The result word sits in an output register, so the next request is
// taken while the previous result waits; a finished probe waits only if that
// register still holds an untaken result. An insert that finds a slot writes
// it on the same cycle its result is loaded; each request's first read is
// issued in the modulo wait state, after the idle and hash states that follow
// the previous write, so the memory needs no forwarding.
module tunnel_ip_hash_map_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    tihm_req_if.sink          req,
    tihm_rsp_if.source        rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    tihm_pkg::tihm_state_t state_reg;
    tihm_pkg::tihm_state_t state_next;

    // request word held for the whole walk
    logic        req_type_reg;
    logic [31:0] key_reg;
    logic [31:0] inner_reg;
    logic [31:0] outer_reg;
    logic [63:0] hash_reg;

    logic [IDX_W-1:0] probe_addr_reg;
    logic [IDX_W-1:0] probe_addr_next;
    logic [IDX_W-1:0] probe_cnt_reg;
    logic [IDX_W-1:0] probe_cnt_next;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;

    // result register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_status_reg;
    logic [31:0] out_found_reg;
    logic [9:0]  out_slot_reg;

    // memory and modulo unit hookup
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    tihm_pkg::slot_entry_t mem_wdata;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    tihm_pkg::slot_entry_t mem_rdata;
    logic                  mod_start;
    logic                  mod_done;
    logic [IDX_W-1:0]      mod_result;

    // probe decode
    logic        accept;
    logic        is_insert;
    logic        entry_match;
    logic        take_slot;
    logic        last_probe;
    logic        finish;
    logic        out_free;
    logic        load_result;
    logic [1:0]  res_status;
    logic [31:0] res_found;
    logic [9:0]  res_slot;

    tihm_mod_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (tihm_pkg::fnv_mul(hash_reg ^ {32'b0, inner_reg})),
        .done  (mod_done),
        .result(mod_result)
    );

    tihm_slot_ram #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (mem_we),
        .wr_addr(mem_waddr),
        .wr_data(mem_wdata),
        .rd_en  (mem_re),
        .rd_addr(mem_raddr),
        .rd_data(mem_rdata)
    );

    assign accept    = req.valid && req.ready;
    assign is_insert = (req_type_reg == tihm_pkg::REQ_INSERT);
    assign out_free  = !out_valid_reg || rsp.ready;

    // both request kinds stop at an empty slot or a key match; they differ in
    // what that stop means
    assign entry_match = mem_rdata.valid && (mem_rdata.tunnel_key == key_reg)
                         && (mem_rdata.inner_addr == inner_reg);
    assign take_slot   = !mem_rdata.valid || entry_match;
    assign last_probe  = (probe_cnt_reg == LAST_IDX);
    assign finish      = take_slot || last_probe;

    always_comb
    begin
        res_status = tihm_pkg::STATUS_MISS;
        res_found  = '0;
        res_slot   = '0;
        if (take_slot)
        begin
            if (is_insert || entry_match)
            begin
                res_status = tihm_pkg::STATUS_OK;
                res_slot   = 10'(probe_addr_reg);
            end
            if (!is_insert && entry_match)
            begin
                res_found = mem_rdata.outer_addr;
            end
        end
        else if (is_insert)
        begin
            // walked the whole table without room
            res_status = tihm_pkg::STATUS_FULL;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tihm_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = tihm_pkg::ST_IDLE;
                end
            end
            tihm_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = tihm_pkg::ST_HASH;
                end
            end
            tihm_pkg::ST_HASH:
            begin
                state_next = tihm_pkg::ST_MOD;
            end
            tihm_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = tihm_pkg::ST_PROBE;
                end
            end
            tihm_pkg::ST_PROBE:
            begin
                if (finish && out_free)
                begin
                    state_next = tihm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tihm_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = probe_addr_reg;
        mem_wdata       = '{valid: 1'b1, tunnel_key: key_reg,
                            inner_addr: inner_reg, outer_addr: outer_reg};
        mem_re          = 1'b0;
        mem_raddr       = probe_addr_reg;
        mod_start       = 1'b0;
        load_result     = 1'b0;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        clr_cnt_next    = clr_cnt_reg;
        case (state_reg)
            tihm_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            tihm_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            tihm_pkg::ST_HASH:
            begin
                mod_start = 1'b1;
            end
            tihm_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = mod_result;
                    probe_addr_next = mod_result;
                    probe_cnt_next  = '0;
                end
            end
            tihm_pkg::ST_PROBE:
            begin
                if (finish)
                begin
                    if (out_free)
                    begin
                        load_result = 1'b1;
                        mem_we      = is_insert && take_slot;
                    end
                end
                else
                begin
                    // wrap to slot zero after the last slot
                    probe_addr_next = (probe_addr_reg == LAST_IDX) ? '0
                                      : probe_addr_reg + 1'b1;
                    probe_cnt_next  = probe_cnt_reg + 1'b1;
                    mem_re          = 1'b1;
                    mem_raddr       = probe_addr_next;
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tihm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            key_reg      <= req.tunnel_key;
            inner_reg    <= req.inner_addr;
            outer_reg    <= req.new_outer_addr;
            hash_reg     <= tihm_pkg::fnv_mul(tihm_pkg::FNV_BASIS ^ {32'b0, req.tunnel_key});
        end
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg  <= probe_cnt_next;
        if (load_result)
        begin
            out_status_reg <= res_status;
            out_found_reg  <= res_found;
            out_slot_reg   <= res_slot;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.found_outer_addr = out_found_reg;
    assign rsp.slot_index       = out_slot_reg;

    // slot memory is written only by the clearing pass or a finishing insert
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == tihm_pkg::ST_CLEAR || state_reg == tihm_pkg::ST_PROBE))
        else $error("slot write outside clear or probe");

    // reduction result arrives only while the sequencer waits for it
    a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == tihm_pkg::ST_MOD))
        else $error("modulo done outside wait state");

    // every insert write is followed by a stored result on the output
    a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == tihm_pkg::ST_PROBE)
        |=> (rsp.valid && rsp.status == tihm_pkg::STATUS_OK))
        else $error("insert write without stored result");

endmodule

FILE: sim/tb_tunnel_ip_hash_map_unit.sv
// tb_tunnel_ip_hash_map_unit: self-checking bench for the tunnel IP hash map.
// Depends on tihm_pkg, tihm_req_if, tihm_rsp_if and tunnel_ip_hash_map_unit.
// A scoreboard keeps its own copy of the map and checks each result word in order.
module tb_tunnel_ip_hash_map_unit;
    import tihm_pkg::*;

    localparam int          MAP_DEPTH    = 1024;
    localparam logic [63:0] FNV_PRIME_64 = 64'h0000_0100_0000_01b3;
    localparam int          MAX_REPORTS  = 100;

    // Collision set: keys sharing one inner address and one home slot.
    localparam logic [31:0] COLLIDE_ADDR = 32'h0a00_0001;
    localparam int          EDGE_SLOT    = MAP_DEPTH - 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] outer_addr;
        logic [9:0]  slot;
    } map_result_t;

    // Receiver stall patterns.
    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_HOLD
    } rx_mode_t;

    //------------------------------------------------------------------
    // Scoreboard: private copy of the map, predicts one result per word.
    //------------------------------------------------------------------
    class tunnel_map_scoreboard;
        bit          occupied  [MAP_DEPTH];
        bit [31:0]   key_mem   [MAP_DEPTH];
        bit [31:0]   inner_mem [MAP_DEPTH];
        bit [31:0]   outer_mem [MAP_DEPTH];
        map_result_t pending[$];
        int          errors;
        int          lookups;
        int          hits;
        int          inserts;
        int          rejected;
        int          checked;
        int          longest_walk;

        static function int home_slot(input logic [31:0] k, input logic [31:0] ip);
            logic [63:0] h;
            h = FNV_BASIS ^ {32'b0, k};
            h = h * FNV_PRIME_64;
            h = h ^ {32'b0, ip};
            h = h * FNV_PRIME_64;
            return int'(h % 64'(MAP_DEPTH));
        endfunction

        function void note_request(input logic t, input logic [31:0] k,
                                   input logic [31:0] ip, input logic [31:0] val);
            map_result_t want;
            int          s;
            int          n;
            bit          same_key;
            s = home_slot(k, ip);
            want.status     = (t == REQ_INSERT) ? STATUS_FULL : STATUS_MISS;
            want.outer_addr = '0;
            want.slot       = '0;
            for (n = 0; n < MAP_DEPTH; n++) begin
                same_key = occupied[s] && key_mem[s] == k && inner_mem[s] == ip;
                if (t == REQ_INSERT) begin
                    if (!occupied[s] || same_key) begin
                        occupied[s]  = 1'b1;
                        key_mem[s]   = k;
                        inner_mem[s] = ip;
                        outer_mem[s] = val;
                        want.status  = STATUS_OK;
                        want.slot    = s[9:0];
                        break;
                    end
                end
                else begin
                    if (same_key) begin
                        want.status     = STATUS_OK;
                        want.outer_addr = outer_mem[s];
                        want.slot       = s[9:0];
                        break;
                    end
                    if (!occupied[s])
                        break;
                end
                s = (s + 1) % MAP_DEPTH;
            end
            if (n + 1 > longest_walk)
                longest_walk = (n < MAP_DEPTH) ? n + 1 : MAP_DEPTH;
            if (t == REQ_INSERT) begin
                inserts++;
                if (want.status == STATUS_FULL)
                    rejected++;
            end
            else begin
                lookups++;
                if (want.status == STATUS_OK)
                    hits++;
            end
            pending.push_back(want);
        endfunction

        function void check_result(input logic [1:0] st, input logic [31:0] outer,
                                   input logic [9:0] idx);
            map_result_t want;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word with nothing pending: status %0d outer %h slot %0d",
                             $time, st, outer, idx);
                return;
            end
            want = pending.pop_front();
            if (st !== want.status) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, st);
            end
            if (outer !== want.outer_addr) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: found_outer_addr mismatch: expected %h, actual %h",
                             $time, want.outer_addr, outer);
            end
            if (idx !== want.slot) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: slot_index mismatch: expected %0d, actual %0d",
                             $time, want.slot, idx);
            end
        endfunction
    endclass

    //------------------------------------------------------------------
    // Clock, channels, block under test
    //------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tihm_req_if req();
    tihm_rsp_if rsp();

    tunnel_ip_hash_map_unit #(
        .TABLE_DEPTH (MAP_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    tunnel_map_scoreboard sb = new();

    // Keys known to be in the map, packed {tunnel_key, inner_addr}.
    logic [63:0] key_pool[$];
    int          burst_left;

    // Receiver pattern state.
    rx_mode_t    rx_mode;
    int          rx_left;

    //------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge.
    // Request first, so a result always pops a word accepted earlier.
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req.valid && req.ready)
                sb.note_request(req.req_type, req.tunnel_key, req.inner_addr,
                                req.new_outer_addr);
            if (rsp.valid && rsp.ready)
                sb.check_result(rsp.status, rsp.found_outer_addr, rsp.slot_index);
        end
    end

    //------------------------------------------------------------------
    // Receiver: ready changes at the falling edge, pattern swaps at random.
    // HOLD is a short total stall; the other patterns run much longer.
    //------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(40, 400);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   rsp.ready <= 1'b1;
            RX_RANDOM: rsp.ready <= ($urandom_range(0, 99) < 70);
            RX_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp.ready <= 1'b0;
        endcase
    end

    //------------------------------------------------------------------
    // Sender: one request word per call, in bursts with random gaps.
    // Called and returns at a falling edge; valid stays high inside a burst.
    //------------------------------------------------------------------
    task automatic send_request(input logic t, input logic [31:0] k,
                                input logic [31:0] ip, input logic [31:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(15, 30);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req.valid          <= 1'b1;
        req.req_type       <= t;
        req.tunnel_key     <= k;
        req.inner_addr     <= ip;
        req.new_outer_addr <= val;
        do
            @(posedge clk);
        while (!req.ready);
        @(negedge clk);
    endtask

    // Insert, and remember the key so later lookups and updates can hit it.
    task automatic add_mapping(input logic [31:0] k, input logic [31:0] ip,
                               input logic [31:0] val);
        bit known;
        known = 1'b0;
        foreach (key_pool[i])
            if (key_pool[i] == {k, ip})
                known = 1'b1;
        if (!known)
            key_pool.push_back({k, ip});
        send_request(REQ_INSERT, k, ip, val);
    endtask

    // Sender pause: hold valid low until every pending result has come back.
    task automatic wait_for_results();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    // Walk tunnel keys upward from seed until one lands on the target slot.
    function automatic logic [31:0] find_key_for_slot(input int target,
                                                      input logic [31:0] ip,
                                                      input logic [31:0] seed);
        logic [31:0] k;
        k = seed;
        while (tunnel_map_scoreboard::home_slot(k, ip) != target)
            k++;
        return k;
    endfunction

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial
    begin
        logic [31:0] c0, c1, c2, c3;
        logic [63:0] pick;
        int          roll;
        int          n;

        rst_n              = 1'b0;
        req.valid          = 1'b0;
        req.req_type       = REQ_LOOKUP;
        req.tunnel_key     = '0;
        req.inner_addr     = '0;
        req.new_outer_addr = '0;
        rsp.ready          = 1'b0;
        burst_left         = 0;
        rx_left            = 0;
        rx_mode            = RX_OPEN;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        // The clearing pass holds req.ready low; the first send just waits.

        // Four keys that all hash to the last slot, so probes wrap to slot 0.
        c0 = find_key_for_slot(EDGE_SLOT, COLLIDE_ADDR, 32'h0000_1000);
        c1 = find_key_for_slot(EDGE_SLOT, COLLIDE_ADDR, c0 + 1);
        c2 = find_key_for_slot(EDGE_SLOT, COLLIDE_ADDR, c1 + 1);
        c3 = find_key_for_slot(EDGE_SLOT, COLLIDE_ADDR, c2 + 1);

        // ---- directed part ----
        send_request(REQ_LOOKUP, 32'h0, 32'h0, 32'hdead_beef);      // empty map miss
        add_mapping(32'h0, 32'h0, 32'h0);                           // all-zero key
        send_request(REQ_LOOKUP, 32'h0, 32'h0, 32'h0);
        add_mapping(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);   // all-ones, outer too
        send_request(REQ_LOOKUP, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
        add_mapping(32'h0, 32'h0, 32'ha5a5_5a5a);                   // update in place
        send_request(REQ_LOOKUP, 32'h0, 32'h0, 32'hffff_ffff);
        send_request(REQ_LOOKUP, 32'h0, 32'hffff_ffff, 32'h0);      // half-matching key
        send_request(REQ_LOOKUP, 32'hffff_ffff, 32'h0, 32'h0);
        add_mapping(c0, COLLIDE_ADDR, 32'h1111_1111);
        add_mapping(c1, COLLIDE_ADDR, 32'h2222_2222);               // wraps to slot 0
        add_mapping(c2, COLLIDE_ADDR, 32'hffff_ffff);
        send_request(REQ_LOOKUP, c2, COLLIDE_ADDR, 32'h0);          // hit after wrap
        send_request(REQ_LOOKUP, c3, COLLIDE_ADDR, 32'h0);          // miss past the run
        add_mapping(c3, COLLIDE_ADDR, 32'h4444_4444);
        send_request(REQ_LOOKUP, c0, COLLIDE_ADDR, 32'h0);
        add_mapping(c1, COLLIDE_ADDR, 32'h8000_0001);               // update mid-cluster
        send_request(REQ_LOOKUP, c1, COLLIDE_ADDR, 32'h0);
        send_request(REQ_LOOKUP, c3, COLLIDE_ADDR, 32'h0);
        add_mapping(32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff);
        send_request(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0001, 32'h0);
        send_request(REQ_LOOKUP, 32'h8000_0000, 32'h0000_0002, 32'h0);
        wait_for_results();

        // ---- random fill: mostly new keys, with hits, updates and misses ----
        // Load climbs to full, so probe runs grow long toward the end.
        while (key_pool.size() < MAP_DEPTH) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                add_mapping($urandom, $urandom, $urandom);
            end
            else if (roll < 78) begin
                pick = key_pool[$urandom_range(0, key_pool.size() - 1)];
                add_mapping(pick[63:32], pick[31:0], $urandom);
            end
            else if (roll < 93) begin
                pick = key_pool[$urandom_range(0, key_pool.size() - 1)];
                send_request(REQ_LOOKUP, pick[63:32], pick[31:0], $urandom);
            end
            else begin
                send_request(REQ_LOOKUP, $urandom, $urandom, $urandom);
            end
        end
        wait_for_results();

        // ---- full map: new inserts are rejected, misses walk every slot ----
        for (n = 0; n < 500; n++) begin
            roll = $urandom_range(0, 99);
            pick = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (roll < 25)
                send_request(REQ_INSERT, $urandom, $urandom, $urandom);
            else if (roll < 50)
                send_request(REQ_INSERT, pick[63:32], pick[31:0], $urandom);
            else if (roll < 80)
                send_request(REQ_LOOKUP, pick[63:32], pick[31:0], $urandom);
            else
                send_request(REQ_LOOKUP, $urandom, $urandom, $urandom);
        end

        // ---- drain, then allow one full walk for any stray word ----
        wait_for_results();
        repeat (2 * MAP_DEPTH) @(negedge clk);

        $display("Checked %0d result words: %0d lookups (%0d hits), %0d inserts (%0d refused on a full map)",
                 sb.checked, sb.lookups, sb.hits, sb.inserts, sb.rejected);
        $display("Longest probe walk %0d slots, %0d mismatches", sb.longest_walk, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    //------------------------------------------------------------------
    // Run limit: many times the slowest correct run (every word a full walk)
    //------------------------------------------------------------------
    initial
    begin
        #200_000_000;
        $display("Timeout with %0d results still pending", sb.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: tunnel_ip_hash_map_unit.f
hdl/tihm_pkg.sv
hdl/tihm_req_if.sv
hdl/tihm_rsp_if.sv
hdl/tihm_slot_ram.sv
hdl/tihm_mod_unit.sv
hdl/tunnel_ip_hash_map_unit.sv
sim/tb_tunnel_ip_hash_map_unit.sv
